### rtl/core/bis_pkg.sv
package bis_pkg;

    localparam int MAX_WIDTH  = 512;
    localparam int MAX_HEIGHT = 512;

    localparam int X_W     = $clog2(MAX_WIDTH);
    localparam int Y_W     = $clog2(MAX_HEIGHT);
    localparam int COORD_W = (X_W > Y_W) ? X_W : Y_W;
    localparam int ADDR_W  = $clog2(MAX_WIDTH * MAX_HEIGHT);
    localparam int DEPTH   = MAX_WIDTH * MAX_HEIGHT;

    localparam int IDX_W   = 9;
    localparam int DIM_W   = 10;
    localparam int SCALE_W = 16;
    localparam int PIX_W   = 24;
    localparam int CHAN_W  = 8;
    localparam int CHANS   = 3;
    localparam int PROD_W  = IDX_W + 1 + SCALE_W;
    localparam int FRAC_W  = 8;
    localparam int LERP_W  = 2 * CHAN_W;
    localparam int SUM_W   = LERP_W + FRAC_W + 1;

    // Half a source pixel in the Q.13 coordinate domain
    localparam logic [PROD_W-1:0] COORD_HALF = PROD_W'(4096);
    localparam logic [CHAN_W-1:0] CHAN_MAX   = 8'hFF;

    localparam logic KIND_LOAD    = 1'b0;
    localparam logic KIND_COMPUTE = 1'b1;

    localparam logic [1:0] CFG_SRC_WIDTH   = 2'd0;
    localparam logic [1:0] CFG_SRC_HEIGHT  = 2'd1;
    localparam logic [1:0] CFG_INV_SCALE_X = 2'd2;
    localparam logic [1:0] CFG_INV_SCALE_Y = 2'd3;

    typedef struct packed {
        logic [COORD_W-1:0] n0;
        logic [COORD_W-1:0] n1;
        logic [FRAC_W-1:0]  f;
    } t_axis;

    typedef enum logic [9:0] {
        S_IDLE = 10'b00_0000_0001,
        S_MAPX = 10'b00_0000_0010,
        S_MAPY = 10'b00_0000_0100,
        S_MAPW = 10'b00_0000_1000,
        S_RD0  = 10'b00_0001_0000,
        S_RD1  = 10'b00_0010_0000,
        S_RD2  = 10'b00_0100_0000,
        S_RD3  = 10'b00_1000_0000,
        S_LAST = 10'b01_0000_0000,
        S_FIN  = 10'b10_0000_0000
    } t_state;

    function automatic logic [ADDR_W-1:0] store_addr(input logic [COORD_W-1:0] col,
                                                    input logic [COORD_W-1:0] row);
        store_addr = ADDR_W'(row) * ADDR_W'(MAX_WIDTH) + ADDR_W'(col);
    endfunction

endpackage

### rtl/core/bis_frame_store.sv
module bis_frame_store
    import bis_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_addr,
    input  logic [PIX_W-1:0]  i_wdata,
    output logic [PIX_W-1:0]  o_rdata
);

    logic [PIX_W-1:0] r_mem [DEPTH];
    logic [PIX_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/core/bis_axis_map.sv
module bis_axis_map
    import bis_pkg::*;
(
    input  logic               i_clk,
    input  logic [IDX_W-1:0]   i_idx,
    input  logic [SCALE_W-1:0] i_inv,
    input  logic [DIM_W-1:0]   i_dim,
    output t_axis              o_axis
);

    logic [PROD_W-1:0] r_prod;
    logic [DIM_W-1:0]  r_dim;
    logic [PROD_W-1:0] s;
    logic [PROD_W-14:0] i0;
    logic [DIM_W-1:0]  dm1;
    logic [DIM_W-1:0]  n0;
    logic [DIM_W:0]    n0p1;
    logic [FRAC_W-1:0] f;

    // (2*idx + 1) * inv gives the source point in Q.13, offset by half a pixel
    always_ff @(posedge i_clk) begin
        r_prod <= PROD_W'({i_idx, 1'b1}) * PROD_W'(i_inv);
        r_dim  <= i_dim;
    end

    always_comb begin
        s   = (r_prod > COORD_HALF) ? (r_prod - COORD_HALF) : '0;
        i0  = s[PROD_W-1:13];
        f   = s[12:5];
        dm1 = r_dim - DIM_W'(1);
        // saturate at the far edge, dropping the weight
        if (i0 >= (PROD_W-13)'(dm1)) begin
            n0 = dm1;
            f  = '0;
        end else begin
            n0 = DIM_W'(i0);
        end
        n0p1 = (DIM_W+1)'(n0) + (DIM_W+1)'(1);
        o_axis.n0 = COORD_W'(n0);
        o_axis.n1 = (n0p1 < (DIM_W+1)'(r_dim)) ? COORD_W'(n0p1) : COORD_W'(dm1);
        o_axis.f  = f;
    end

endmodule

### rtl/core/bis_lerp.sv
module bis_lerp
    import bis_pkg::*;
(
    input  logic [CHANS-1:0][LERP_W-1:0] i_a,
    input  logic [CHANS-1:0][LERP_W-1:0] i_b,
    input  logic [FRAC_W-1:0]            i_f,
    output logic [CHANS-1:0][SUM_W-1:0]  o_sum
);

    logic [FRAC_W:0] w0;

    assign w0 = (FRAC_W+1)'(256) - (FRAC_W+1)'(i_f);

    always_comb begin
        for (int k = 0; k < CHANS; k++) begin
            o_sum[k] = SUM_W'(i_a[k]) * SUM_W'(w0) + SUM_W'(i_b[k]) * SUM_W'(i_f);
        end
    end

endmodule

### rtl/core/bilinear_image_scaler.sv
// Load item: written to the frame store at acceptance, ready again next cycle.
// Compute item: o_ready stays low from acceptance until the result is registered,
// so a new item is taken only after the present pixel, and FIN holds while the output
// stalls; the work is four reads of the one-port store, two axis mappings and three passes of the shared blend unit.
// Synchronous active-low reset clears the sequencer, output valid and configuration registers;
// frame store contents are undefined until loaded.
module bilinear_image_scaler
    import bis_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic               i_kind,
    input  logic [IDX_W-1:0]   i_column,
    input  logic [IDX_W-1:0]   i_row,
    input  logic [PIX_W-1:0]   i_pixel_in,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [PIX_W-1:0]   o_pixel_out,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_addr,
    input  logic [SCALE_W-1:0] i_cfg_data
);

    t_state r_state, n_state;

    logic [DIM_W-1:0]   r_src_width, r_src_height;
    logic [SCALE_W-1:0] r_inv_x, r_inv_y;
    logic [IDX_W-1:0]   r_col, r_row;
    t_axis              r_ax, r_ay, map_out;
    logic [PIX_W-1:0]   r_p00, r_p10;
    logic [CHANS-1:0][LERP_W-1:0] r_top, r_bot;
    logic [PIX_W-1:0]   r_pixel_out;
    logic               r_out_valid;

    logic [DIM_W-1:0]   dim_x, dim_y;
    logic [IDX_W-1:0]   map_idx;
    logic [SCALE_W-1:0] map_inv;
    logic [DIM_W-1:0]   map_dim;
    logic               accept, load_we, out_free;
    logic [ADDR_W-1:0]  mem_addr;
    logic [PIX_W-1:0]   rd_data;
    logic [CHANS-1:0][LERP_W-1:0] lerp_a, lerp_b;
    logic [FRAC_W-1:0]  lerp_f;
    logic [CHANS-1:0][SUM_W-1:0]  lerp_sum;

    assign o_ready  = (r_state == S_IDLE);
    assign accept   = i_valid && o_ready;
    assign out_free = !r_out_valid || i_ready;
    assign load_we  = accept && (i_kind == KIND_LOAD)
                      && (32'(i_column) < 32'(MAX_WIDTH)) && (32'(i_row) < 32'(MAX_HEIGHT));

    always_comb begin
        dim_x = r_src_width;
        if (r_src_width == '0) begin
            dim_x = DIM_W'(1);
        end else if (32'(r_src_width) > 32'(MAX_WIDTH)) begin
            dim_x = DIM_W'(MAX_WIDTH);
        end
        dim_y = r_src_height;
        if (r_src_height == '0) begin
            dim_y = DIM_W'(1);
        end else if (32'(r_src_height) > 32'(MAX_HEIGHT)) begin
            dim_y = DIM_W'(MAX_HEIGHT);
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: if (i_valid && i_kind == KIND_COMPUTE) n_state = S_MAPX;
            S_MAPX: n_state = S_MAPY;
            S_MAPY: n_state = S_MAPW;
            S_MAPW: n_state = S_RD0;
            S_RD0:  n_state = S_RD1;
            S_RD1:  n_state = S_RD2;
            S_RD2:  n_state = S_RD3;
            S_RD3:  n_state = S_LAST;
            S_LAST: n_state = S_FIN;
            S_FIN:  if (out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_out_valid  <= 1'b0;
            r_src_width  <= DIM_W'(512);
            r_src_height <= DIM_W'(512);
            r_inv_x      <= SCALE_W'(4096);
            r_inv_y      <= SCALE_W'(4096);
        end else begin
            r_state <= n_state;
            if (r_state == S_FIN && out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    CFG_SRC_WIDTH:   r_src_width  <= i_cfg_data[DIM_W-1:0];
                    CFG_SRC_HEIGHT:  r_src_height <= i_cfg_data[DIM_W-1:0];
                    CFG_INV_SCALE_X: r_inv_x      <= i_cfg_data;
                    CFG_INV_SCALE_Y: r_inv_y      <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    // shared axis mapper: x issued in MAPX, y in MAPY, each result taken in the next cycle
    always_comb begin
        map_idx = r_row;
        map_inv = r_inv_y;
        map_dim = dim_y;
        if (r_state == S_MAPX) begin
            map_idx = r_col;
            map_inv = r_inv_x;
            map_dim = dim_x;
        end
    end

    bis_axis_map u_map (
        .i_clk  (i_clk),
        .i_idx  (map_idx),
        .i_inv  (map_inv),
        .i_dim  (map_dim),
        .o_axis (map_out)
    );

    always_comb begin
        case (r_state)
            S_RD0:   mem_addr = store_addr(r_ax.n0, r_ay.n0);
            S_RD1:   mem_addr = store_addr(r_ax.n1, r_ay.n0);
            S_RD2:   mem_addr = store_addr(r_ax.n0, r_ay.n1);
            S_RD3:   mem_addr = store_addr(r_ax.n1, r_ay.n1);
            default: mem_addr = store_addr(COORD_W'(i_column), COORD_W'(i_row));
        endcase
    end

    bis_frame_store u_store (
        .i_clk   (i_clk),
        .i_we    (load_we),
        .i_addr  (mem_addr),
        .i_wdata (i_pixel_in),
        .o_rdata (rd_data)
    );

    // blend top pair in RD2, bottom pair in LAST, rows in FIN
    always_comb begin
        lerp_f = r_ax.f;
        for (int k = 0; k < CHANS; k++) begin
            lerp_a[k] = LERP_W'(r_p00[k*CHAN_W +: CHAN_W]);
            lerp_b[k] = LERP_W'(rd_data[k*CHAN_W +: CHAN_W]);
            if (r_state == S_LAST) begin
                lerp_a[k] = LERP_W'(r_p10[k*CHAN_W +: CHAN_W]);
            end
            if (r_state == S_FIN) begin
                lerp_a[k] = r_top[k];
                lerp_b[k] = r_bot[k];
            end
        end
        if (r_state == S_FIN) begin
            lerp_f = r_ay.f;
        end
    end

    bis_lerp u_lerp (
        .i_a   (lerp_a),
        .i_b   (lerp_b),
        .i_f   (lerp_f),
        .o_sum (lerp_sum)
    );

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_col <= i_column;
            r_row <= i_row;
        end
        if (r_state == S_MAPY) begin
            r_ax <= map_out;
        end
        if (r_state == S_MAPW) begin
            r_ay <= map_out;
        end
        if (r_state == S_RD1) begin
            r_p00 <= rd_data;
        end
        if (r_state == S_RD3) begin
            r_p10 <= rd_data;
        end
        for (int k = 0; k < CHANS; k++) begin
            if (r_state == S_RD2) begin
                r_top[k] <= lerp_sum[k][LERP_W-1:0];
            end
            if (r_state == S_LAST) begin
                r_bot[k] <= lerp_sum[k][LERP_W-1:0];
            end
            if (r_state == S_FIN && out_free) begin
                r_pixel_out[k*CHAN_W +: CHAN_W] <= lerp_sum[k][SUM_W-1] ? CHAN_MAX
                                                   : lerp_sum[k][SUM_W-2 -: CHAN_W];
            end
        end
    end

    assign o_valid     = r_out_valid;
    assign o_pixel_out = r_pixel_out;

endmodule
